[design/tla_pkg.sv]
// Shared types, constants and helper functions for the text line annotator.
package tla_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int CNT_W         = 4 * NUMBER_DIGITS;
    localparam int STEP_W        = $clog2(NUMBER_DIGITS + 4);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_ADDR_W    = 3;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUMBER_ALL      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARK_LINE_ENDS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARK_TABS       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SQUEEZE_BLANKS  = 3'd4;

    localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_beat_t;

    typedef struct packed {
        logic number_all_lines;
        logic number_nonblank_lines;
        logic mark_line_ends;
        logic mark_tabs;
        logic squeeze_blanks;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_TAB,
        KIND_NL
    } kind_t;

    // One queued command: everything the back end needs to expand a byte.
    typedef struct packed {
        logic             numbered;
        logic [CNT_W-1:0] digits;
        kind_t            kind;
        logic             dollar;
        logic [7:0]       ch;
    } cmd_t;

    // Saturating BCD increment: all nines stays all nines.
    function automatic logic [CNT_W-1:0] bcd_increment(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        logic             carry;
        logic             all_nines;
        logic [3:0]       d;
        r         = v;
        carry     = 1'b1;
        all_nines = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            d = v[4*i +: 4];
            if (d != 4'd9)
                all_nines = 1'b0;
            if (carry)
            begin
                if (d >= 4'd9)
                    d = 4'd0;
                else
                begin
                    d     = d + 4'd1;
                    carry = 1'b0;
                end
            end
            r[4*i +: 4] = d;
        end
        return all_nines ? v : r;
    endfunction

    // Character at a position of the right-justified number, most
    // significant digit first; leading zeros show as spaces.
    function automatic logic [7:0] number_char(input logic [CNT_W-1:0]  v,
                                               input logic [STEP_W-1:0] step);
        logic       lead;
        logic [7:0] ch;
        logic [3:0] d;
        lead = 1'b1;
        ch   = CH_SPACE;
        for (int s = 0; s < NUMBER_DIGITS; s++)
        begin
            d = v[4*(NUMBER_DIGITS-1-s) +: 4];
            if (d != 4'd0 || s == NUMBER_DIGITS - 1)
                lead = 1'b0;
            if (STEP_W'(s) == step)
                ch = lead ? CH_SPACE : (CH_ZERO + {4'd0, d});
        end
        return ch;
    endfunction

endpackage

[design/tla_front.sv]
// Front end: accepts input beats, tracks line state and the counter, issues commands.
module tla_front
    import tla_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     accept,
    input  in_beat_t beat,
    output logic     cmd_push,
    output cmd_t     cmd
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             line_start_reg, line_start_next;
    logic             last_blank_reg, last_blank_next;

    logic [CNT_W-1:0] eff_count;
    logic             eff_start;
    logic             eff_blank;
    logic             blank;
    logic             squeeze;
    logic             numbered;

    always_comb
    begin
        eff_count = beat.file_start ? COUNT_ONE : count_reg;
        eff_start = beat.file_start | line_start_reg;
        eff_blank = beat.file_start ? 1'b0 : last_blank_reg;
        blank     = (beat.in_byte == CH_NL);
        squeeze   = eff_start & cfg.squeeze_blanks & blank & eff_blank;
        if (!eff_start)
            numbered = 1'b0;
        else if (cfg.number_nonblank_lines)
            numbered = ~blank;
        else
            numbered = cfg.number_all_lines;

        cmd.numbered = numbered;
        cmd.digits   = eff_count;
        cmd.dollar   = cfg.mark_line_ends;
        cmd.ch       = beat.in_byte;
        if (blank)
            cmd.kind = KIND_NL;
        else if (beat.in_byte == CH_TAB && cfg.mark_tabs)
            cmd.kind = KIND_TAB;
        else
            cmd.kind = KIND_PLAIN;

        cmd_push = accept & ~squeeze;

        count_next      = count_reg;
        line_start_next = line_start_reg;
        last_blank_next = last_blank_reg;
        if (accept && !squeeze)
        begin
            count_next      = numbered ? bcd_increment(eff_count) : eff_count;
            line_start_next = blank;
            last_blank_next = eff_start ? blank : eff_blank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_ONE;
            line_start_reg <= 1'b1;
            last_blank_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            line_start_reg <= line_start_next;
            last_blank_reg <= last_blank_next;
        end
    end

endmodule

[design/tla_queue.sv]
// Short command queue between the front and back ends.
module tla_queue
    import tla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_pop;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (!push && do_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[design/tla_back.sv]
// Back end: expands each command into output beats, one per cycle unless stalled.
module tla_back
    import tla_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head_cmd,
    output logic      head_pop,
    input  logic      pop,
    output logic      empty,
    output out_beat_t result
);

    localparam logic [STEP_W-1:0] PREFIX_LEN = STEP_W'(NUMBER_DIGITS + 2);
    localparam logic [STEP_W-1:0] DIGIT_LEN  = STEP_W'(NUMBER_DIGITS);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_reg, out_next;

    logic              in_prefix;
    logic [STEP_W-1:0] body_idx;
    logic [STEP_W-1:0] body_len;
    logic              last;
    logic [7:0]        ch;
    logic              emit;

    always_comb
    begin
        in_prefix = head_cmd.numbered && (step_reg < PREFIX_LEN);
        body_idx  = head_cmd.numbered ? step_reg - PREFIX_LEN : step_reg;

        case (head_cmd.kind)
            KIND_TAB:   body_len = STEP_W'(2);
            KIND_NL:    body_len = head_cmd.dollar ? STEP_W'(2) : STEP_W'(1);
            KIND_PLAIN: body_len = STEP_W'(1);
            default:    body_len = STEP_W'(1);
        endcase
        last = ~in_prefix & (body_idx == body_len - 1'b1);

        if (in_prefix)
            ch = (step_reg < DIGIT_LEN) ? number_char(head_cmd.digits, step_reg) : CH_SPACE;
        else
        begin
            case (head_cmd.kind)
                KIND_TAB:   ch = (body_idx == '0) ? CH_CARET : CH_I;
                KIND_NL:    ch = (head_cmd.dollar && body_idx == '0) ? CH_DOLLAR : CH_NL;
                KIND_PLAIN: ch = head_cmd.ch;
                default:    ch = head_cmd.ch;
            endcase
        end

        // Advance only when the output register is free or being drained.
        emit     = head_valid & (~out_valid_reg | pop);
        head_pop = emit & last;

        step_next      = step_reg;
        out_valid_next = out_valid_reg & ~pop;
        out_next       = out_reg;
        if (emit)
        begin
            step_next         = last ? '0 : step_reg + 1'b1;
            out_valid_next    = 1'b1;
            out_next.out_byte = ch;
            out_next.run_last = last;
        end
    end

    assign empty  = ~out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[design/text_line_annotator.sv]
// Top level of the text line annotator: configuration registers and the front/queue/back chain.
//
// A cat-style line filter. Input beats carry one text byte and a file-start
// flag; output beats carry one character and run_last, set on the final
// character produced for an input byte. A stream of plain bytes flows at one
// beat per cycle while the receiver keeps popping. A numbered line start adds
// NUMBER_DIGITS+2 output beats (digits right-justified with spaces, then two
// spaces), a marked tab gives two beats and a marked line end gives two; the
// back end emits one output beat per cycle while its output register is free
// or popped; an item gives at most NUMBER_DIGITS+4 beats. A two-entry command
// queue sits between the front end and the back end, so input keeps flowing
// while an expansion drains, and full rises only once both entries wait. A
// squeezed blank line is accepted and produces no output beat. Write the
// configuration only while the block is idle. The line counter saturates at
// all nines and returns to 1 on file_start.
module text_line_annotator
    import tla_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input queue side
    input  logic                  push,
    input  in_beat_t              in_item,
    output logic                  full,
    // result queue side
    input  logic                  pop,
    output logic                  empty,
    output out_beat_t             result,
    // configuration writes
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic                  cfg_wdata
);

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic cmd_push;
    cmd_t cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic head_pop;

    // Decode the register index; unknown indexes drop the write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_NUMBER_ALL:      cfg_next.number_all_lines      = cfg_wdata;
                CFG_NUMBER_NONBLANK: cfg_next.number_nonblank_lines = cfg_wdata;
                CFG_MARK_LINE_ENDS:  cfg_next.mark_line_ends        = cfg_wdata;
                CFG_MARK_TABS:       cfg_next.mark_tabs             = cfg_wdata;
                CFG_SQUEEZE_BLANKS:  cfg_next.squeeze_blanks        = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // Take an input beat whenever the command queue has room.
    assign accept = push & ~full;

    tla_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .beat     (in_item),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    tla_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tla_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

[bench/text_line_annotator_checker.sv]
// Scoreboard for the text line annotator: predicts the output characters and checks every beat.
`timescale 1ns / 100ps

module text_line_annotator_checker
    import tla_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  in_beat_t              in_item,
    input  logic                  pop,
    input  logic                  empty,
    input  out_beat_t             result,
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic                  cfg_wdata,
    output int                    errors,
    output int                    outstanding,
    output int                    chars_checked,
    output int                    squeezed_lines
);

    cfg_t             opts;
    logic [CNT_W-1:0] line_no;
    logic             line_start;
    logic             prev_blank;
    out_beat_t        expected_chars[$];

    // Expand one text byte into the characters it should produce.
    task automatic annotate(input in_beat_t b);
        logic [7:0] c;
        logic [7:0] chars[$];
        logic       blank;
        logic       numbered;
        logic       leading;
        logic       carry;
        logic [3:0] digit;
        out_beat_t  beat;
        c = b.in_byte;
        if (b.file_start)
        begin
            line_no    = COUNT_ONE;
            line_start = 1'b1;
            prev_blank = 1'b0;
        end
        if (line_start)
        begin
            blank = (c == CH_NL);
            if (opts.squeeze_blanks && blank && prev_blank)
            begin
                squeezed_lines++;
                return;
            end
            numbered = opts.number_nonblank_lines ? !blank : opts.number_all_lines;
            if (numbered)
            begin
                leading = 1'b1;
                for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
                begin
                    digit = line_no[4*i +: 4];
                    if (digit != 4'd0 || i == 0)
                        leading = 1'b0;
                    chars.push_back(leading ? CH_SPACE : CH_ZERO + 8'(digit));
                end
                chars.push_back(CH_SPACE);
                chars.push_back(CH_SPACE);
                // Saturating decimal count.
                if (line_no != {NUMBER_DIGITS{4'd9}})
                begin
                    carry = 1'b1;
                    for (int i = 0; i < NUMBER_DIGITS; i++)
                    begin
                        if (carry)
                        begin
                            if (line_no[4*i +: 4] == 4'd9)
                                line_no[4*i +: 4] = 4'd0;
                            else
                            begin
                                line_no[4*i +: 4] = line_no[4*i +: 4] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
            end
            prev_blank = blank;
        end
        if (c == CH_TAB && opts.mark_tabs)
        begin
            chars.push_back(CH_CARET);
            chars.push_back(CH_I);
            line_start = 1'b0;
        end
        else if (c == CH_NL)
        begin
            if (opts.mark_line_ends)
                chars.push_back(CH_DOLLAR);
            chars.push_back(CH_NL);
            line_start = 1'b1;
        end
        else
        begin
            chars.push_back(c);
            line_start = 1'b0;
        end
        foreach (chars[k])
        begin
            beat.out_byte = chars[k];
            beat.run_last = (k == chars.size() - 1);
            expected_chars.push_back(beat);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            opts           = '0;
            line_no        = COUNT_ONE;
            line_start     = 1'b1;
            prev_blank     = 1'b0;
            expected_chars = {};
            errors         = 0;
            chars_checked  = 0;
            squeezed_lines = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    CFG_NUMBER_ALL:      opts.number_all_lines      = cfg_wdata;
                    CFG_NUMBER_NONBLANK: opts.number_nonblank_lines = cfg_wdata;
                    CFG_MARK_LINE_ENDS:  opts.mark_line_ends        = cfg_wdata;
                    CFG_MARK_TABS:       opts.mark_tabs             = cfg_wdata;
                    CFG_SQUEEZE_BLANKS:  opts.squeeze_blanks        = cfg_wdata;
                    default: ;
                endcase
            end
            // Predict before checking, so a same-edge result still finds its entry.
            if (push && !full)
                annotate(in_item);
            if (pop && !empty)
            begin
                chars_checked++;
                if (expected_chars.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, got char %h last %b",
                             $time, result.out_byte, result.run_last);
                end
                else
                begin
                    if (result.out_byte !== expected_chars[0].out_byte)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %h, got %h", $time,
                                 expected_chars[0].out_byte, result.out_byte);
                    end
                    if (result.run_last !== expected_chars[0].run_last)
                    begin
                        errors++;
                        $display("%0t: run_last expected %b, got %b", $time,
                                 expected_chars[0].run_last, result.run_last);
                    end
                    void'(expected_chars.pop_front());
                end
            end
        end
        outstanding = expected_chars.size();
    end

endmodule

[bench/text_line_annotator_tb.sv]
// Top of the text line annotator bench: clock, reset, text stimulus, flow control and verdict.
`timescale 1ns / 100ps

module text_line_annotator_tb;
    import tla_pkg::*;

    // Upper bound on the cycles an accepted byte may still be in flight.
    localparam int DRAIN_CYCLES   = 4 * (NUMBER_DIGITS + 4);
    localparam int PHASES         = 8;
    localparam int PHASE_BEATS    = 43;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_t;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    in_beat_t              in_item;
    logic                  full;
    logic                  pop;
    logic                  empty;
    out_beat_t             result;
    logic                  cfg_wen;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic                  cfg_wdata;

    int    errors;
    int    outstanding;
    int    chars_checked;
    int    squeezed_lines;
    int    beats_sent;
    int    hold_requests;
    int    holds_done;
    flow_t flow;

    text_line_annotator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    text_line_annotator_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .in_item        (in_item),
        .pop            (pop),
        .empty          (empty),
        .result         (result),
        .cfg_wen        (cfg_wen),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .errors         (errors),
        .outstanding    (outstanding),
        .chars_checked  (chars_checked),
        .squeezed_lines (squeezed_lines)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_beat_t make_beat(input logic [7:0] ch, input logic fs);
        in_beat_t b;
        b.in_byte    = ch;
        b.file_start = fs;
        return b;
    endfunction

    // Offer one beat, with random idle cycles in front of it, and hold it until taken.
    task automatic send_beat(input in_beat_t b);
        int idle_pct;
        idle_pct = (flow == FLOW_SENDER_IDLE) ? 71 : (flow == FLOW_BOTH) ? 12 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= b;
        do
            @(posedge clk);
        while (full);
        beats_sent++;
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++)
            send_beat(make_beat(s[k], 1'b0));
    endtask

    // Mostly printable text, a fair share of tabs, some arbitrary bytes as noise.
    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return CH_TAB;
        if (r < 22)
            return 8'($urandom_range(255));
        return 8'($urandom_range(8'h7E, 8'h20));
    endfunction

    // One line of random content; about a third are blank, so blank runs show up often.
    task automatic send_random_line();
        int len;
        len = ($urandom_range(99) < 32) ? 0 : $urandom_range(7, 1);
        for (int k = 0; k < len; k++)
            send_beat(make_beat(random_text_byte(), $urandom_range(999) < 6));
        send_beat(make_beat(CH_NL, $urandom_range(999) < 6));
    endtask

    task automatic write_option(input logic [CFG_ADDR_W-1:0] addr, input logic val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic apply_options(input cfg_t o);
        write_option(CFG_NUMBER_ALL, o.number_all_lines);
        write_option(CFG_NUMBER_NONBLANK, o.number_nonblank_lines);
        write_option(CFG_MARK_LINE_ENDS, o.mark_line_ends);
        write_option(CFG_MARK_TABS, o.mark_tabs);
        write_option(CFG_SQUEEZE_BLANKS, o.squeeze_blanks);
        cfg_wen <= 1'b0;
    endtask

    // Wait out every expected character, then let a squeezed line finish inside the block.
    task automatic settle();
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls per flow phase; a requested long hold lets the block back up.
    initial
    begin
        int stall_pct;
        pop        <= 1'b0;
        holds_done  = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall_pct = (flow == FLOW_RECEIVER_STALL) ? 71 : (flow == FLOW_BOTH) ? 12 : 0;
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("text_line_annotator_tb: FAIL");
        $finish;
    end

    initial
    begin
        cfg_t opts;
        int   phase_start;
        push          <= 1'b0;
        in_item       <= '0;
        cfg_wen       <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= 1'b0;
        rst_n         <= 1'b0;
        hold_requests  = 0;
        beats_sent     = 0;
        flow           = FLOW_FREE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: numbering, both markers and squeezing on together.
        opts                       = '0;
        opts.number_all_lines      = 1'b1;
        opts.mark_line_ends        = 1'b1;
        opts.mark_tabs             = 1'b1;
        opts.squeeze_blanks        = 1'b1;
        apply_options(opts);
        send_beat(make_beat("A", 1'b1));
        // Tab as line content, then a blank line followed by two that get squeezed.
        send_str("\t\n\n\n\n");
        send_beat(make_beat(8'h00, 1'b0));
        send_beat(make_beat(8'hFF, 1'b0));
        send_beat(make_beat(8'h80, 1'b0));
        send_str("\n\tz\n");
        // File start on a blank line restarts the count; the next blank line is squeezed.
        send_beat(make_beat(CH_NL, 1'b1));
        send_str("\n");
        push <= 1'b0;
        settle();

        // Non-blank numbering overrides number-all; no markers, no squeezing.
        opts.number_nonblank_lines = 1'b1;
        opts.mark_line_ends        = 1'b0;
        opts.mark_tabs             = 1'b0;
        opts.squeeze_blanks        = 1'b0;
        apply_options(opts);
        send_str("\n\nq\t\n");
        send_beat(make_beat(CH_TAB, 1'b1));
        send_str("\n");
        push <= 1'b0;

        // Phases: extremes first, then two fixed option sets, then random option sets under each flow pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: opts = '0;
                1: opts = '1;
                2:
                begin
                    opts                  = '0;
                    opts.number_all_lines = 1'b1;
                    opts.squeeze_blanks   = 1'b1;
                end
                3:
                begin
                    opts                       = '0;
                    opts.number_nonblank_lines = 1'b1;
                    opts.mark_line_ends        = 1'b1;
                end
                default: opts = cfg_t'(5'($urandom_range(31)));
            endcase
            apply_options(opts);
            flow = flow_t'(p % 4);
            if (p == 2)
                hold_requests <= hold_requests + 1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
                send_random_line();
            push <= 1'b0;
        end
        settle();

        $display("Sent %0d text bytes under %0d option sets; checked %0d output chars.",
                 beats_sent, PHASES + 2, chars_checked);
        $display("Squeezed %0d blank lines; one long receiver hold filled the block.",
                 squeezed_lines);
        if (errors == 0 && outstanding == 0)
            $display("text_line_annotator_tb: PASS");
        else
            $display("text_line_annotator_tb: FAIL");
        $finish;
    end

endmodule
